// ===== rtl/core/rrt_pkg.sv =====
// ---------------------------------------------------------------------------
// rrt_pkg
// shared types and constants of the recency rank tracker
// ---------------------------------------------------------------------------
package rrt_pkg;

    // key space and slot sizing
    localparam int KEY_W       = 10;
    localparam int KEY_FIELD   = 1 << KEY_W;
    localparam int NUM_KEYS    = 1024;
    localparam int KEY_SPAN    = (NUM_KEYS < KEY_FIELD) ? NUM_KEYS : KEY_FIELD;
    localparam int NUM_SLOTS   = KEY_SPAN;
    localparam int SLOT_W      = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
    localparam int COUNT_W     = $clog2(NUM_SLOTS + 1);

    // match encoder grouping
    localparam int GROUP_SIZE  = 32;
    localparam int GROUP_W     = 5;
    localparam int NUM_GROUPS  = (NUM_SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GROUP_IDX_W = (NUM_GROUPS > 2) ? $clog2(NUM_GROUPS) : 1;
    localparam int MATCH_W     = NUM_GROUPS * GROUP_SIZE;
    localparam int ENC_IDX_W   = GROUP_IDX_W + GROUP_W;

    // result fields
    localparam int RANK_W      = 11;
    localparam logic [RANK_W-1:0] RANK_NONE = {RANK_W{1'b1}};

    // stream packing
    localparam int IN_DATA_W   = 16;
    localparam int OUT_FIELD_W = 1 + 3 * RANK_W;
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    // action codes
    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENC1,
        ST_ENC2,
        ST_UPDATE
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic [KEY_W-1:0]   probe_key;
        logic [COUNT_W-1:0] count;
        logic               shift_en;
        logic               append_en;
        logic [SLOT_W-1:0]  lo;
        logic [SLOT_W-1:0]  top;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/recency_rank_tracker.sv =====
// ---------------------------------------------------------------------------
// recency_rank_tracker
// per-key recency rank in true lru stack order
// ---------------------------------------------------------------------------
// The ranks live as a stack in a row of 1024 cells: cell r holds the key whose
// rank is r, and the fill count marks how many cells are in use. An item is
// accepted in the idle cycle, every cell compares its key to the probe key,
// a two-stage registered encoder turns the single match into the old rank,
// and in the update cycle the cell at the old rank and those above it take
// their upper neighbor's key while the top cell takes the probe key (first
// access: the key is written at the fill mark). No new item is taken until
// the last one has passed its update, and the update waits while the output
// register still holds an untaken result; once it is held there, the next
// transaction is taken while the result waits. The end-of-array flag clears
// the fill count with the result, which empties the stack in the same cycle:
// there is no clearing pass after reset or between arrays.
// ---------------------------------------------------------------------------
module recency_rank_tracker (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rrt_pkg::IN_DATA_W-1:0]   s_tdata,   // key[9:0], zero pad
    input  logic                            s_tuser,   // action
    input  logic                            s_tlast,   // end_of_array

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rrt_pkg::OUT_DATA_W-1:0]  m_tdata,   // was_new, old_rank[10:0],
                                                       // new_rank[10:0],
                                                       // distinct_count[10:0], pad
    output logic                            m_tlast    // last
);

    // fsm
    rrt_pkg::state_t state_reg;
    rrt_pkg::state_t state_next;

    // captured transaction
    logic [rrt_pkg::KEY_W-1:0]   key_reg;
    logic                        action_reg;
    logic                        last_reg;

    // fill count of the stack
    logic [rrt_pkg::COUNT_W-1:0] count_reg;
    logic [rrt_pkg::COUNT_W-1:0] count_next;

    // output register
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [rrt_pkg::OUT_DATA_W-1:0] m_data_reg;
    logic [rrt_pkg::OUT_DATA_W-1:0] m_data_next;
    logic                           m_last_reg;
    logic                           m_last_next;

    // cell row
    rrt_pkg::cell_ctrl_t          ctrl;
    logic [rrt_pkg::NUM_SLOTS-1:0] match_vec;
    logic [rrt_pkg::KEY_W-1:0]    cell_key [rrt_pkg::NUM_SLOTS];
    logic                         enc_hit;
    logic [rrt_pkg::SLOT_W-1:0]   enc_idx;

    // update cycle
    logic                         s_fire;
    logic                         upd_fire;
    logic                         in_span;
    logic                         is_access;
    logic [rrt_pkg::COUNT_W-1:0]  count_dec;
    logic [rrt_pkg::COUNT_W-1:0]  count_after;
    logic [rrt_pkg::RANK_W-1:0]   old_rank;
    logic [rrt_pkg::RANK_W-1:0]   new_rank;
    logic                         was_new;

    // -----------------------------------------------------------------------
    // control state machine
    // -----------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rrt_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = rrt_pkg::ST_ENC1;
                end
            end
            rrt_pkg::ST_ENC1: begin
                state_next = rrt_pkg::ST_ENC2;
            end
            rrt_pkg::ST_ENC2: begin
                state_next = rrt_pkg::ST_UPDATE;
            end
            rrt_pkg::ST_UPDATE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = rrt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        upd_fire = 1'b0;
        unique case (state_reg)
            rrt_pkg::ST_IDLE:   s_tready = 1'b1;
            rrt_pkg::ST_ENC1:   s_tready = 1'b0;
            rrt_pkg::ST_ENC2:   s_tready = 1'b0;
            rrt_pkg::ST_UPDATE: upd_fire = !m_valid_reg || m_tready;
            default:            s_tready = 1'b0;
        endcase
    end

    assign s_fire = s_tvalid && s_tready;

    // -----------------------------------------------------------------------
    // update decision and result
    // -----------------------------------------------------------------------
    always_comb begin
        in_span   = 32'(key_reg) < rrt_pkg::KEY_SPAN;
        is_access = action_reg == rrt_pkg::ACT_ACCESS;
        count_dec = count_reg - rrt_pkg::COUNT_W'(1);

        ctrl.probe_key = key_reg;
        ctrl.count     = count_reg;
        ctrl.shift_en  = upd_fire && in_span && is_access && enc_hit;
        ctrl.append_en = upd_fire && in_span && is_access && !enc_hit;
        ctrl.lo        = enc_idx;
        ctrl.top       = count_dec[rrt_pkg::SLOT_W-1:0];

        was_new     = in_span && is_access && !enc_hit;
        count_after = was_new ? count_reg + rrt_pkg::COUNT_W'(1) : count_reg;

        old_rank = (in_span && enc_hit) ? rrt_pkg::RANK_W'(enc_idx) : rrt_pkg::RANK_NONE;
        if (!in_span) begin
            new_rank = rrt_pkg::RANK_NONE;
        end else if (is_access) begin
            new_rank = enc_hit ? rrt_pkg::RANK_W'(count_dec) : rrt_pkg::RANK_W'(count_reg);
        end else begin
            new_rank = old_rank;
        end

        // end of array empties the stack along with its result
        count_next = count_reg;
        if (upd_fire) begin
            count_next = last_reg ? '0 : count_after;
        end
    end

    // -----------------------------------------------------------------------
    // output register, takes a result whenever it is free or being drained
    // -----------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (upd_fire) begin
            m_valid_next = 1'b1;
            m_data_next  = {{rrt_pkg::OUT_PAD_W{1'b0}},
                            rrt_pkg::RANK_W'(count_after),
                            new_rank,
                            old_rank,
                            was_new};
            m_last_next  = last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rrt_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            key_reg    <= s_tdata[rrt_pkg::KEY_W-1:0];
            action_reg <= s_tuser;
            last_reg   <= s_tlast;
        end
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    // -----------------------------------------------------------------------
    // cell row, each cell reads its upper neighbor
    // -----------------------------------------------------------------------
    for (genvar i = 0; i < rrt_pkg::NUM_SLOTS; i++) begin : g_cell
        logic [rrt_pkg::KEY_W-1:0] right_key;
        if (i == rrt_pkg::NUM_SLOTS - 1) begin : g_end
            assign right_key = key_reg;
        end else begin : g_mid
            assign right_key = cell_key[i+1];
        end

        rrt_cell u_cell (
            .aclk      (aclk),
            .cell_idx  (rrt_pkg::SLOT_W'(i)),
            .ctrl      (ctrl),
            .right_key (right_key),
            .key_out   (cell_key[i]),
            .match     (match_vec[i])
        );
    end

    rrt_match_enc u_enc (
        .aclk  (aclk),
        .match (match_vec),
        .hit   (enc_hit),
        .idx   (enc_idx)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== rtl/core/rrt_cell.sv =====
// ---------------------------------------------------------------------------
// rrt_cell
// one slot of the recency stack, holds the key that owns this rank
// ---------------------------------------------------------------------------
module rrt_cell (
    input  logic                        aclk,
    input  logic [rrt_pkg::SLOT_W-1:0]  cell_idx,
    input  rrt_pkg::cell_ctrl_t         ctrl,
    input  logic [rrt_pkg::KEY_W-1:0]   right_key,
    output logic [rrt_pkg::KEY_W-1:0]   key_out,
    output logic                        match
);

    logic [rrt_pkg::KEY_W-1:0]   key_reg;
    logic [rrt_pkg::KEY_W-1:0]   key_next;
    logic [rrt_pkg::COUNT_W-1:0] idx_c;
    logic                        in_use;

    always_comb begin
        idx_c  = rrt_pkg::COUNT_W'(cell_idx);
        in_use = idx_c < ctrl.count;
        match  = in_use && (key_reg == ctrl.probe_key);
    end

    // repeat access: the slot at the old rank and those above it take their upper neighbor,
    // the top slot takes the probe key; first access appends at the fill mark
    always_comb begin
        key_next = key_reg;
        if (ctrl.shift_en && (cell_idx == ctrl.top)) begin
            key_next = ctrl.probe_key;
        end else if (ctrl.shift_en && (cell_idx >= ctrl.lo) && (cell_idx < ctrl.top)) begin
            key_next = right_key;
        end else if (ctrl.append_en && (idx_c == ctrl.count)) begin
            key_next = ctrl.probe_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key_out = key_reg;

endmodule

// ===== rtl/core/rrt_match_enc.sv =====
// ---------------------------------------------------------------------------
// rrt_match_enc
// two-stage registered encoder from the cell match vector to a rank
// ---------------------------------------------------------------------------
module rrt_match_enc (
    input  logic                          aclk,
    input  logic [rrt_pkg::NUM_SLOTS-1:0] match,
    output logic                          hit,
    output logic [rrt_pkg::SLOT_W-1:0]    idx
);

    logic [rrt_pkg::MATCH_W-1:0]    match_pad;
    logic [rrt_pkg::NUM_GROUPS-1:0] grp_hit_next;
    logic [rrt_pkg::NUM_GROUPS-1:0] grp_hit_reg;
    logic [rrt_pkg::GROUP_W-1:0]    grp_lo_next [rrt_pkg::NUM_GROUPS];
    logic [rrt_pkg::GROUP_W-1:0]    grp_lo_reg  [rrt_pkg::NUM_GROUPS];
    logic                           hit_next;
    logic                           hit_reg;
    logic [rrt_pkg::ENC_IDX_W-1:0]  idx_next;
    logic [rrt_pkg::ENC_IDX_W-1:0]  idx_reg;

    assign match_pad = rrt_pkg::MATCH_W'(match);

    // stage one: hit and low index inside each group
    always_comb begin
        for (int g = 0; g < rrt_pkg::NUM_GROUPS; g++) begin
            grp_hit_next[g] = 1'b0;
            grp_lo_next[g]  = '0;
            for (int j = 0; j < rrt_pkg::GROUP_SIZE; j++) begin
                if (match_pad[g * rrt_pkg::GROUP_SIZE + j]) begin
                    grp_hit_next[g] = 1'b1;
                    grp_lo_next[g]  = grp_lo_next[g] | rrt_pkg::GROUP_W'(j);
                end
            end
        end
    end

    // stage two: at most one group hits, so an or of the tagged indexes
    always_comb begin
        hit_next = |grp_hit_reg;
        idx_next = '0;
        for (int g = 0; g < rrt_pkg::NUM_GROUPS; g++) begin
            if (grp_hit_reg[g]) begin
                idx_next = idx_next | {rrt_pkg::GROUP_IDX_W'(g), grp_lo_reg[g]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        grp_hit_reg <= grp_hit_next;
        grp_lo_reg  <= grp_lo_next;
        hit_reg     <= hit_next;
        idx_reg     <= idx_next;
    end

    assign hit = hit_reg;
    assign idx = idx_reg[rrt_pkg::SLOT_W-1:0];

endmodule

// ===== rtl/core/rrt_checker.sv =====
// ---------------------------------------------------------------------------
// rrt_checker
// port-level checks of the recency rank tracker
// ---------------------------------------------------------------------------
module rrt_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [rrt_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            m_tlast
);

    logic                         was_new;
    logic [rrt_pkg::RANK_W-1:0]   old_rank;
    logic [rrt_pkg::RANK_W-1:0]   new_rank;
    logic [rrt_pkg::RANK_W-1:0]   distinct;

    assign was_new  = m_tdata[0];
    assign old_rank = m_tdata[11:1];
    assign new_rank = m_tdata[22:12];
    assign distinct = m_tdata[33:23];

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // a first access had no rank and lands on the newest rank
    a_new_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && was_new |->
            old_rank == rrt_pkg::RANK_NONE &&
            (new_rank + rrt_pkg::RANK_W'(1)) == distinct)
        else $error("first access rank mismatch");

    // an assigned rank stays below the distinct count
    a_rank_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && new_rank != rrt_pkg::RANK_NONE |-> new_rank < distinct)
        else $error("rank beyond distinct count");

    // distinct count never exceeds the key space
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(distinct) <= rrt_pkg::NUM_SLOTS)
        else $error("distinct count overflow");

endmodule

bind recency_rank_tracker rrt_checker u_rrt_checker (.*);

// ===== bench/recency_rank_tracker_tb.sv =====
// ---------------------------------------------------------------------------
// recency_rank_tracker_tb
// self-checking bench for the lru recency rank tracker
// ---------------------------------------------------------------------------
// Drives key accesses and rank lookups into the input stream and checks every
// result transaction against a rank table kept inside the bench. Directed
// tasks cover first accesses, repeat accesses at the bottom, middle and top of
// the stack, lookups of ranked and unranked keys and the end-of-array clear.
// These are followed by random arrays. Both stream sides idle and stall at
// random.
// ---------------------------------------------------------------------------
module recency_rank_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STUCK_LIMIT   = 2000;   // cycles with no transaction on either side
    localparam int RANDOM_ITEMS  = 500;
    localparam int DRAIN_CYCLES  = 12;

    // one result transaction, fields from the top down, last on top and was_new at bit 0
    typedef struct packed {
        logic                       last;
        logic [rrt_pkg::RANK_W-1:0] distinct_count;
        logic [rrt_pkg::RANK_W-1:0] new_rank;
        logic [rrt_pkg::RANK_W-1:0] old_rank;
        logic                       was_new;
    } rank_result_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [rrt_pkg::IN_DATA_W-1:0]   s_tdata  = '0;   // key[9:0], zero pad
    logic                            s_tuser  = 1'b0; // action
    logic                            s_tlast  = 1'b0; // end_of_array
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [rrt_pkg::OUT_DATA_W-1:0]  m_tdata;         // was_new, old_rank, new_rank,
                                                      // distinct_count, pad
    logic                            m_tlast;         // last

    // bench copy of the rank store
    bit                          key_ranked [rrt_pkg::KEY_SPAN];
    logic [rrt_pkg::RANK_W-1:0]  key_rank   [rrt_pkg::KEY_SPAN];
    logic [rrt_pkg::RANK_W-1:0]  keys_seen;

    rank_result_t           expected_results[$];
    int                     mismatches  = 0;
    int                     stuck_cycles = 0;
    bit                     idle_on     = 1'b1;   // random gaps and stalls enabled
    int                     rx_hold     = 0;

    recency_rank_tracker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // rank store model
    // ------------------------------------------------------------------
    function automatic void clear_ranks();
        int i;
        for (i = 0; i < rrt_pkg::KEY_SPAN; i++) begin
            key_ranked[i] = 1'b0;
            key_rank[i]   = '0;
        end
        keys_seen = '0;
    endfunction

    // applies one input item to the store and returns the result it causes
    function automatic rank_result_t apply_item(logic act, logic [rrt_pkg::KEY_W-1:0] k,
                                                logic eoa);
        rank_result_t               r;
        logic [rrt_pkg::RANK_W-1:0] prev;
        int                         i;
        r.was_new  = 1'b0;
        r.old_rank = rrt_pkg::RANK_NONE;
        r.new_rank = rrt_pkg::RANK_NONE;
        if (k < rrt_pkg::KEY_SPAN) begin
            r.old_rank = key_ranked[k] ? key_rank[k] : rrt_pkg::RANK_NONE;
            if (act == rrt_pkg::ACT_ACCESS) begin
                if (!key_ranked[k]) begin
                    // first access takes the next free rank
                    key_ranked[k] = 1'b1;
                    key_rank[k]   = keys_seen;
                    keys_seen     = keys_seen + 1'b1;
                    r.was_new     = 1'b1;
                end else begin
                    // repeat access: everything above the old rank slides down once
                    prev = key_rank[k];
                    for (i = 0; i < rrt_pkg::KEY_SPAN; i++) begin
                        if (i != k && key_ranked[i] && key_rank[i] > prev)
                            key_rank[i] = key_rank[i] - 1'b1;
                    end
                    key_rank[k] = keys_seen - 1'b1;
                end
            end
            r.new_rank = key_ranked[k] ? key_rank[k] : rrt_pkg::RANK_NONE;
        end
        r.distinct_count = keys_seen;
        r.last           = eoa;
        // end of array empties the whole store after the result
        if (eoa)
            clear_ranks();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input side: one transaction with a random lead-in gap
    // ------------------------------------------------------------------
    task automatic send_item(input logic act, input logic [rrt_pkg::KEY_W-1:0] k,
                             input logic eoa);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(rrt_pkg::IN_DATA_W - rrt_pkg::KEY_W){1'b0}}, k};
        s_tuser  <= act;
        s_tlast  <= eoa;
        do @(posedge aclk); while (!s_tready);
        expected_results = {expected_results, apply_item(act, k, eoa)};
    endtask

    // ------------------------------------------------------------------
    // result side: ready stalls and field checks
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [rrt_pkg::RANK_W-1:0] exp_v,
                               input logic [rrt_pkg::RANK_W-1:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, name, exp_v, exp_v, got_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        rank_result_t want;
        rank_result_t got;
        if (!aresetn) begin
            rx_hold  = 0;
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tlast, m_tdata[rrt_pkg::OUT_FIELD_W-1:0]};
                if (expected_results.size() == 0) begin
                    $display("%0t: result transaction with nothing expected, actual 0x%0h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("was_new", rrt_pkg::RANK_W'(want.was_new),
                                rrt_pkg::RANK_W'(got.was_new));
                    check_field("old_rank",       want.old_rank,        got.old_rank);
                    check_field("new_rank",       want.new_rank,        got.new_rank);
                    check_field("distinct_count", want.distinct_count,  got.distinct_count);
                    check_field("last", rrt_pkg::RANK_W'(want.last),
                                rrt_pkg::RANK_W'(got.last));
                end
                rx_hold = idle_on ? $urandom_range(0, 3) : 0;
            end else if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
            end
            m_tready <= (rx_hold == 0);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transaction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin : watchdog
        while (stuck_cycles < STUCK_LIMIT) @(posedge aclk);
        $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // first accesses take ranks 0, 1, 2, 3; lookup of a key never seen
    task automatic test_first_access();
        idle_on = 1'b0;
        send_item(rrt_pkg::ACT_ACCESS, 10'd0,    1'b0);
        send_item(rrt_pkg::ACT_ACCESS, 10'd1023, 1'b0);
        send_item(rrt_pkg::ACT_ACCESS, 10'd5,    1'b0);
        send_item(rrt_pkg::ACT_LOOKUP, 10'd7,    1'b0);
        send_item(rrt_pkg::ACT_ACCESS, 10'd512,  1'b0);
    endtask

    // repeat access from bottom, middle and top of the stack
    task automatic test_repeat_access();
        idle_on = 1'b1;
        send_item(rrt_pkg::ACT_ACCESS, 10'd0,    1'b0);   // bottom rank moves to the top
        send_item(rrt_pkg::ACT_ACCESS, 10'd0,    1'b0);   // already on top, nothing moves
        send_item(rrt_pkg::ACT_ACCESS, 10'd5,    1'b0);   // middle rank
        send_item(rrt_pkg::ACT_LOOKUP, 10'd1023, 1'b0);
        send_item(rrt_pkg::ACT_LOOKUP, 10'd0,    1'b0);
        send_item(rrt_pkg::ACT_ACCESS, 10'd1023, 1'b0);
        send_item(rrt_pkg::ACT_LOOKUP, 10'd341,  1'b1);   // end of array on a lookup
    endtask

    // store clears after the last item of an array
    task automatic test_end_of_array();
        send_item(rrt_pkg::ACT_LOOKUP, 10'd0,    1'b0);   // cleared: unranked again
        send_item(rrt_pkg::ACT_ACCESS, 10'd682,  1'b1);   // one-item array, first access
        send_item(rrt_pkg::ACT_ACCESS, 10'd682,  1'b0);   // rank 0 again
        send_item(rrt_pkg::ACT_ACCESS, 10'd3,    1'b0);
        send_item(rrt_pkg::ACT_ACCESS, 10'd682,  1'b1);   // repeat access closes the array
        send_item(rrt_pkg::ACT_LOOKUP, 10'd1023, 1'b1);   // empty array of one lookup
    endtask

    // random arrays, mostly over a small key pool so repeats are common
    task automatic test_random_arrays();
        int                        sent;
        int                        len;
        int                        n;
        int                        pool_base;
        int                        pool_size;
        bit                        wide;
        logic                      act;
        logic [rrt_pkg::KEY_W-1:0] k;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_on   = ($urandom_range(0, 3) != 0);
            wide      = ($urandom_range(0, 7) == 0);
            len       = wide ? $urandom_range(60, 150) : $urandom_range(1, 40);
            pool_base = $urandom_range(0, 1023);
            pool_size = $urandom_range(2, 16);
            for (n = 0; n < len; n++) begin
                act = ($urandom_range(0, 3) == 0) ? rrt_pkg::ACT_LOOKUP : rrt_pkg::ACT_ACCESS;
                if (wide || $urandom_range(0, 7) == 0)
                    k = rrt_pkg::KEY_W'($urandom_range(0, 1023));
                else
                    k = rrt_pkg::KEY_W'((pool_base + $urandom_range(0, pool_size - 1))
                                        % rrt_pkg::KEY_FIELD);
                send_item(act, k, n == len - 1);
            end
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        clear_ranks();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_first_access();
        test_repeat_access();
        test_end_of_array();
        test_random_arrays();

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
